[hw/rtl/pfe_pkg.sv]
`timescale 1ns / 1ps

package pfe_pkg;

   typedef logic [4:0] letter_type;
   typedef logic [4:0] addr_type;
   typedef logic [2:0] rc_type;

   localparam letter_type LETTER_X  = 5'd23;
   localparam letter_type LETTER_J  = 5'd9;
   localparam letter_type LETTER_I  = 5'd8;
   localparam letter_type ALPHABET  = 5'd26;
   localparam addr_type   CELLS     = 5'd25;
   localparam rc_type     SIDE      = 3'd5;
   localparam rc_type     END_SHIFT = 3'd3;

   typedef enum logic [2:0] {
      CMD_CLEAR  = 3'd0,
      CMD_KEY    = 3'd1,
      CMD_FINISH = 3'd2,
      CMD_PLAIN  = 3'd3,
      CMD_END    = 3'd4
   } cmd_type;

   typedef struct packed {
      addr_type a;
      addr_type b;
   } addr_pair_type;

   // row of a cell: p/5 as (p*13)>>6, exact for 0..24
   function automatic rc_type pos_row(input addr_type p);
      logic [9:0] prod;
      prod = 10'(p) * 10'd13;
      return rc_type'(prod >> 6);
   endfunction

   function automatic rc_type pos_col(input addr_type p);
      rc_type r;
      r = pos_row(p);
      return rc_type'(p - addr_type'(5'(r) * 5'(SIDE)));
   endfunction

   function automatic rc_type wrap_inc(input rc_type v);
      return (v == SIDE - 3'd1) ? 3'd0 : v + 3'd1;
   endfunction

   function automatic addr_type cell_addr(input rc_type r, input rc_type c);
      return addr_type'(5'(r) * 5'(SIDE) + 5'(c));
   endfunction

   // cell addresses of the two output letters for a pair or a lone letter
   function automatic addr_pair_type cipher_addr(input addr_type p, input addr_type q,
                                                 input logic lone);
      rc_type        r1;
      rc_type        c1;
      rc_type        r2;
      rc_type        c2;
      rc_type        cs;
      addr_pair_type res;
      r1 = pos_row(p);
      c1 = pos_col(p);
      r2 = pos_row(q);
      c2 = pos_col(q);
      cs = c1 + END_SHIFT;
      if (cs >= SIDE) begin
         cs = cs - SIDE;
      end
      if (lone) begin
         res.a = cell_addr(r1, cs);
         res.b = cell_addr(SIDE - 3'd1, c1);
      end else if (r1 == r2) begin
         res.a = cell_addr(r1, wrap_inc(c1));
         res.b = cell_addr(r2, wrap_inc(c2));
      end else if (c1 == c2) begin
         res.a = cell_addr(wrap_inc(r1), c1);
         res.b = cell_addr(wrap_inc(r2), c2);
      end else begin
         res.a = cell_addr(r1, c2);
         res.b = cell_addr(r2, c1);
      end
      return res;
   endfunction

endpackage

[hw/rtl/playfair_encryptor.sv]
`timescale 1ns / 1ps

// Playfair encryptor over letter indices a=0 .. z=25.
// Request channel (req_*): tuser carries the command (clear, key letter, finish key,
// plaintext letter, end of message), tdata the letter. Response channel (rsp_*):
// tdata carries a cipher letter, tlast marks the second letter of each emitted pair.
// One request is worked on at a time; req_tready is high only while the block is idle.
// Clear, key letters and requests that start no cipher pair are done in the cycle in
// which they are taken. Finish walks the alphabet through the shared placement path,
// one letter a cycle. A plaintext letter that completes a pair, or an end of message
// with a lone letter, reads two positions and then two cells through the single read
// ports of the position and square memories (via ST_POSB, ST_CALC, ST_SQB); the first
// letter is shown in ST_OUT0, the second in ST_OUT1 once the first is taken.
// When rsp_tready is low the current letter holds on rsp_tdata and no new request
// is taken. Reset clears the used-letter marks, the fill count and the pending
// letter; the square and position memories keep their contents and need no
// clearing pass.
module playfair_encryptor
   import pfe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [4:0] letter, [7:5] zero
   input  logic [2:0] req_tuser,   // [2:0] cmd
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [4:0] cipher_letter, [7:5] zero
   output logic       rsp_tlast
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_POSB,
      ST_CALC,
      ST_SQB,
      ST_OUT0,
      ST_OUT1
   } state_type;

   state_type            state_ff;
   logic [ALPHABET-1:0]  letter_used_ff;
   addr_type             fill_count_ff;
   logic                 pending_valid_ff;
   letter_type           pending_letter_ff;
   letter_type           fill_idx_ff;
   letter_type           second_ff;
   logic                 lone_ff;
   addr_type             p_ff;
   addr_type             addr_b_ff;
   letter_type           cell_a_ff;

   letter_type           square_ff [CELLS];
   addr_type             position_ff [ALPHABET];
   letter_type           sq_rd_ff;
   addr_type             pos_rd_ff;

   cmd_type              cmd;
   letter_type           letter_raw;
   logic                 letter_ok;
   letter_type           letter_map;
   logic                 accept;
   letter_type           place_letter;
   logic                 place_en;
   logic                 do_place;
   letter_type           second;
   logic                 plain_used;
   logic                 pair_go;
   logic                 end_go;
   letter_type           pos_raddr;
   logic                 pos_re;
   addr_type             sq_raddr;
   logic                 sq_re;
   addr_pair_type        addrs;

   assign cmd        = cmd_type'(req_tuser);
   assign letter_raw = req_tdata[4:0];
   assign letter_ok  = letter_raw < ALPHABET;
   assign letter_map = (letter_raw == LETTER_J) ? LETTER_I : letter_raw;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // key letters and the finish sweep share one placement path
   assign place_letter = (state_ff == ST_FILL) ? fill_idx_ff : letter_map;
   assign place_en     = (accept && cmd == CMD_KEY && letter_ok)
                      || (state_ff == ST_FILL && fill_idx_ff != LETTER_J);
   assign do_place     = place_en && fill_count_ff < CELLS && !letter_used_ff[place_letter];

   assign plain_used = letter_ok && letter_used_ff[letter_map];
   assign second     = (letter_map == pending_letter_ff) ? LETTER_X : letter_map;
   assign pair_go    = accept && cmd == CMD_PLAIN && plain_used && pending_valid_ff
                    && letter_used_ff[second] && letter_used_ff[pending_letter_ff];
   assign end_go     = accept && cmd == CMD_END && pending_valid_ff;

   assign pos_raddr = (state_ff == ST_IDLE) ? pending_letter_ff : second_ff;
   assign pos_re    = (state_ff == ST_IDLE) || (state_ff == ST_POSB);
   assign addrs     = cipher_addr(p_ff, pos_rd_ff, lone_ff);
   assign sq_raddr  = (state_ff == ST_CALC) ? addrs.a : addr_b_ff;
   assign sq_re     = (state_ff == ST_CALC) || (state_ff == ST_SQB);

   assign rsp_tvalid = (state_ff == ST_OUT0) || (state_ff == ST_OUT1);
   assign rsp_tlast  = (state_ff == ST_OUT1);
   assign rsp_tdata  = {3'b000, (state_ff == ST_OUT1) ? sq_rd_ff : cell_a_ff};

   always_ff @(posedge clock) begin
      if (do_place) begin
         square_ff[fill_count_ff] <= place_letter;
      end
      if (sq_re) begin
         sq_rd_ff <= square_ff[sq_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (do_place) begin
         position_ff[place_letter] <= fill_count_ff;
      end
      if (pos_re) begin
         pos_rd_ff <= position_ff[pos_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         letter_used_ff    <= '0;
         fill_count_ff     <= '0;
         pending_valid_ff  <= 1'b0;
         pending_letter_ff <= '0;
         fill_idx_ff       <= '0;
         lone_ff           <= 1'b0;
      end else begin
         if (do_place) begin
            letter_used_ff[place_letter] <= 1'b1;
            fill_count_ff                <= fill_count_ff + 5'd1;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  unique case (cmd)
                     CMD_CLEAR: begin
                        letter_used_ff   <= '0;
                        fill_count_ff    <= '0;
                        pending_valid_ff <= 1'b0;
                     end
                     CMD_FINISH: begin
                        fill_idx_ff <= '0;
                        state_ff    <= ST_FILL;
                     end
                     CMD_PLAIN: begin
                        if (plain_used) begin
                           if (!pending_valid_ff) begin
                              pending_valid_ff  <= 1'b1;
                              pending_letter_ff <= letter_map;
                           end else if (letter_map != pending_letter_ff) begin
                              pending_valid_ff <= 1'b0;
                           end
                        end
                        if (pair_go) begin
                           second_ff <= second;
                           lone_ff   <= 1'b0;
                           state_ff  <= ST_POSB;
                        end
                     end
                     CMD_END: begin
                        if (end_go) begin
                           pending_valid_ff <= 1'b0;
                           second_ff        <= pending_letter_ff;
                           lone_ff          <= 1'b1;
                           state_ff         <= ST_POSB;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_FILL: begin
               if (fill_idx_ff == ALPHABET - 5'd1) begin
                  state_ff <= ST_IDLE;
               end
               fill_idx_ff <= fill_idx_ff + 5'd1;
            end
            ST_POSB: begin
               p_ff     <= pos_rd_ff;
               state_ff <= ST_CALC;
            end
            ST_CALC: begin
               addr_b_ff <= addrs.b;
               state_ff  <= ST_SQB;
            end
            ST_SQB: begin
               cell_a_ff <= sq_rd_ff;
               state_ff  <= ST_OUT0;
            end
            ST_OUT0: begin
               if (rsp_tready) begin
                  state_ff <= ST_OUT1;
               end
            end
            ST_OUT1: begin
               if (rsp_tready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTH
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= CELLS)
      else $error("fill count beyond square size");

   a_busy_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while a response is pending");

   a_idle_after_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready)
      else $error("not idle after second letter");

   a_pending_used: assert property (@(posedge clock) disable iff (reset)
      pending_valid_ff |-> letter_used_ff[pending_letter_ff])
      else $error("pending letter not in square");

   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && rsp_tlast)
      else $error("first letter not followed by second");
`endif

endmodule

[tb/tb_playfair_encryptor.sv]
`timescale 1ns / 1ps

module tb_playfair_encryptor;
   import pfe_pkg::*;

   localparam logic [2:0] CMD_SPARE_LO = 3'd5;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;
   localparam letter_type LETTER_TOP   = 5'd31;
   localparam int         HOLD_CYCLES  = 300;

   typedef struct {
      letter_type letter;
      logic       last;
   } cipher_item_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;    // [4:0] letter, [7:5] zero
   logic [2:0] req_tuser;    // [2:0] cmd
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;    // [4:0] cipher_letter, [7:5] zero
   logic       rsp_tlast;

   // shadow of the block: square, placement marks and the held plaintext letter
   letter_type      pf_square [CELLS];
   logic            placed_mask [ALPHABET];
   addr_type        placed_at [ALPHABET];
   int unsigned     filled_cells = 0;
   logic            held_valid = 1'b0;
   letter_type      held_letter = '0;
   cipher_item_type cipher_q [$];

   int mismatch_count = 0;
   int send_idle_pct = 0;
   int rcv_idle_pct = 0;
   bit hold_off_armed = 1'b0;
   int hold_left = 0;

   playfair_encryptor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   initial begin
      foreach (placed_mask[i]) placed_mask[i] = 1'b0;
   end

   function automatic letter_type ltr(input byte ch);
      return letter_type'(ch - "a");
   endfunction

   function automatic void place_letter(input letter_type l);
      if (filled_cells < CELLS && !placed_mask[l]) begin
         pf_square[filled_cells] = l;
         placed_at[l]            = addr_type'(filled_cells);
         placed_mask[l]          = 1'b1;
         filled_cells++;
      end
   endfunction

   function automatic letter_type square_at(input int unsigned r, input int unsigned c);
      return pf_square[(r % SIDE) * SIDE + (c % SIDE)];
   endfunction

   function automatic void push_pair(input letter_type a, input letter_type b);
      cipher_q.push_back('{a, 1'b0});
      cipher_q.push_back('{b, 1'b1});
   endfunction

   // expected cipher letters caused by one accepted request
   function automatic void predict_cipher(input logic [2:0] cmd, input letter_type l_in);
      letter_type  l;
      letter_type  first;
      letter_type  second;
      int unsigned r1;
      int unsigned c1;
      int unsigned r2;
      int unsigned c2;
      l = l_in;
      case (cmd)
         CMD_CLEAR: begin
            foreach (placed_mask[i]) placed_mask[i] = 1'b0;
            filled_cells = 0;
            held_valid   = 1'b0;
         end
         CMD_KEY: begin
            if (l < ALPHABET) begin
               if (l == LETTER_J) l = LETTER_I;
               place_letter(l);
            end
         end
         CMD_FINISH: begin
            for (int z = 0; z < ALPHABET; z++) begin
               if (z != LETTER_J) place_letter(letter_type'(z));
            end
         end
         CMD_PLAIN: begin
            if (l < ALPHABET) begin
               if (l == LETTER_J) l = LETTER_I;
               if (placed_mask[l]) begin
                  if (!held_valid) begin
                     held_valid  = 1'b1;
                     held_letter = l;
                  end else begin
                     first = held_letter;
                     // doubled letter pairs with x and stays held
                     if (l == first) begin
                        second = LETTER_X;
                     end else begin
                        second     = l;
                        held_valid = 1'b0;
                     end
                     if (placed_mask[first] && placed_mask[second]) begin
                        r1 = placed_at[first] / SIDE;
                        c1 = placed_at[first] % SIDE;
                        r2 = placed_at[second] / SIDE;
                        c2 = placed_at[second] % SIDE;
                        if (r1 == r2) begin
                           push_pair(square_at(r1, c1 + 1), square_at(r2, c2 + 1));
                        end else if (c1 == c2) begin
                           push_pair(square_at(r1 + 1, c1), square_at(r2 + 1, c2));
                        end else begin
                           push_pair(square_at(r1, c2), square_at(r2, c1));
                        end
                     end
                  end
               end
            end
         end
         CMD_END: begin
            if (held_valid) begin
               held_valid = 1'b0;
               r1 = placed_at[held_letter] / SIDE;
               c1 = placed_at[held_letter] % SIDE;
               push_pair(square_at(r1, c1 + END_SHIFT), square_at(SIDE - 1, c1));
            end
         end
         default: ;
      endcase
   endfunction

   task automatic send_request(input logic [2:0] cmd, input letter_type l);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {3'b000, l};
      do @(posedge clock); while (!req_tready);
      predict_cipher(cmd, l);
   endtask

   // receiver: random stalls plus an optional long hold-off
   always @(posedge clock) begin
      if (hold_off_armed) begin
         hold_left      = HOLD_CYCLES;
         hold_off_armed = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cipher_item_type exp_item;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (cipher_q.size() == 0) begin
            $error("unexpected response: cipher_letter %0d last %0b",
                   rsp_tdata[4:0], rsp_tlast);
            mismatch_count++;
         end else begin
            exp_item = cipher_q.pop_front();
            if (rsp_tdata[4:0] !== exp_item.letter) begin
               $error("cipher_letter: expected %0d, got %0d", exp_item.letter, rsp_tdata[4:0]);
               mismatch_count++;
            end
            if (rsp_tlast !== exp_item.last) begin
               $error("last: expected %0b, got %0b", exp_item.last, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   // nothing to work with yet: all of these are dropped
   task automatic test_idle_commands();
      send_request(CMD_END, '0);
      send_request(CMD_PLAIN, ltr("a"));
      send_request(CMD_SPARE_LO, ltr("b"));
      send_request(CMD_SPARE_HI, LETTER_TOP);
   endtask

   // square: i z a b c / d e f g h / k l m n o / p q r s t / u v w x y
   task automatic test_square_build();
      send_request(CMD_CLEAR, '0);
      send_request(CMD_KEY, LETTER_J);
      send_request(CMD_KEY, LETTER_I);
      send_request(CMD_KEY, LETTER_TOP);
      send_request(CMD_KEY, ltr("z"));
      send_request(CMD_FINISH, '0);
   endtask

   task automatic test_pair_rules();
      send_request(CMD_PLAIN, ltr("d"));     // same row
      send_request(CMD_PLAIN, ltr("f"));
      send_request(CMD_PLAIN, ltr("i"));     // same column
      send_request(CMD_PLAIN, ltr("d"));
      send_request(CMD_PLAIN, ltr("a"));     // rectangle
      send_request(CMD_PLAIN, ltr("h"));
      send_request(CMD_PLAIN, ltr("e"));     // doubled letter, then e g
      send_request(CMD_PLAIN, ltr("e"));
      send_request(CMD_PLAIN, ltr("g"));
      send_request(CMD_PLAIN, LETTER_X);    // doubled x, x stays held
      send_request(CMD_PLAIN, LETTER_X);
      send_request(CMD_END, '0);            // lone x at end of message
      send_request(CMD_PLAIN, LETTER_J);
      send_request(CMD_PLAIN, ALPHABET);    // out of range, dropped
      send_request(CMD_PLAIN, ltr("k"));
   endtask

   // x not placed: the a,x pair gives nothing; end reads leftover cells
   task automatic test_missing_filler();
      send_request(CMD_CLEAR, '0);
      send_request(CMD_KEY, ltr("a"));
      send_request(CMD_PLAIN, ltr("a"));
      send_request(CMD_PLAIN, ltr("a"));
      send_request(CMD_END, '0);
   endtask

   task automatic test_input_backpressure();
      send_request(CMD_CLEAR, '0);
      repeat (3) send_request(CMD_KEY, letter_type'($urandom_range(0, 25)));
      send_request(CMD_FINISH, '0);
      hold_off_armed = 1'b1;
      repeat (16) send_request(CMD_PLAIN, letter_type'($urandom_range(0, 25)));
      send_request(CMD_END, '0);
   endtask

   task automatic test_random_messages(input int send_pct, input int rcv_pct,
                                       input int target);
      int         sent;
      int         nkey;
      int         nmsg;
      int         pick;
      letter_type prev;
      letter_type l;
      sent          = 0;
      send_idle_pct = send_pct;
      rcv_idle_pct  = rcv_pct;
      while (sent < target) begin
         if ($urandom_range(0, 99) < 85) begin
            send_request(CMD_CLEAR, letter_type'($urandom_range(0, 31)));
            nkey = $urandom_range(0, 8);
            repeat (nkey) send_request(CMD_KEY, letter_type'($urandom_range(0, 25)));
            // sometimes cipher with a partly built square
            if ($urandom_range(0, 9) != 0) begin
               send_request(CMD_FINISH, letter_type'($urandom_range(0, 31)));
            end
            nmsg = $urandom_range(1, 14);
            prev = letter_type'($urandom_range(0, 25));
            repeat (nmsg) begin
               pick = $urandom_range(0, 9);
               if (pick < 3) begin
                  l = prev;
               end else if (pick == 3) begin
                  l = LETTER_X;
               end else if (pick == 4) begin
                  l = LETTER_J;
               end else begin
                  l = letter_type'($urandom_range(0, 25));
               end
               send_request(CMD_PLAIN, l);
               prev = l;
            end
            if ($urandom_range(0, 4) != 0) begin
               send_request(CMD_END, letter_type'($urandom_range(0, 31)));
            end
            sent += 2 + nkey + nmsg;
         end else begin
            repeat ($urandom_range(1, 4)) begin
               send_request(3'($urandom_range(0, 7)), letter_type'($urandom_range(0, 31)));
            end
         end
      end
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= CMD_CLEAR;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_idle_commands();
      test_square_build();
      test_pair_rules();
      test_missing_filler();
      test_input_backpressure();
      test_random_messages(24, 69, 150);
      test_random_messages(69, 24, 150);
      test_random_messages(0, 0, 150);

      req_tvalid <= 1'b0;
      while (cipher_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
